FILE: hw/rtl/aabbt_pkg.sv
`timescale 1ns / 1ps

package aabbt_pkg;

	localparam int COORD_W  = 32;
	localparam int COEFF_W  = 16;
	localparam int ROW_W    = 3 * COEFF_W;
	localparam int CFG_W    = (ROW_W > COORD_W) ? ROW_W : COORD_W;
	localparam int RSHIFT   = COEFF_W - 1;
	localparam int SUM_W    = COORD_W + 1;
	localparam int PROD_W   = COEFF_W + SUM_W;
	localparam int ACC_W    = PROD_W + 2;
	localparam int EXT_W    = ACC_W - RSHIFT;
	localparam int CTR_W    = EXT_W + 1;
	localparam int CORNER_W = CTR_W + 1;

	localparam logic [ROW_W-1:0] COEFF_ONE = ROW_W'(1) << (COEFF_W - 2);
	localparam logic [ROW_W-1:0] ROW_X_RST = COEFF_ONE;
	localparam logic [ROW_W-1:0] ROW_Y_RST = COEFF_ONE << COEFF_W;
	localparam logic [ROW_W-1:0] ROW_Z_RST = COEFF_ONE << (2 * COEFF_W);

	typedef enum logic [2:0] {
		REG_ROW_X   = 3'd0,
		REG_ROW_Y   = 3'd1,
		REG_ROW_Z   = 3'd2,
		REG_SHIFT_X = 3'd3,
		REG_SHIFT_Y = 3'd4,
		REG_SHIFT_Z = 3'd5
	} reg_idx_t;

	localparam int REG_IDX_W = $bits(reg_idx_t);

	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

FILE: hw/rtl/aabbt_axis.sv
`timescale 1ns / 1ps

module aabbt_axis (
	input  logic                                    clk,
	input  aabbt_pkg::stage_en_t                    en,
	input  logic [aabbt_pkg::ROW_W-1:0]             row,
	input  logic signed [aabbt_pkg::COORD_W-1:0]    shift,
	input  aabbt_pkg::sum_t                         sum_s1 [3],
	input  aabbt_pkg::sum_t                         dif_s1 [3],
	output logic signed [aabbt_pkg::COORD_W-1:0]    lower_s5,
	output logic signed [aabbt_pkg::COORD_W-1:0]    upper_s5,
	output logic                                    clip_s5
);
	import aabbt_pkg::*;

	localparam logic signed [CORNER_W-1:0] SAT_MAX =
		CORNER_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
	localparam logic signed [CORNER_W-1:0] SAT_MIN = -SAT_MAX - CORNER_W'(1);

	logic signed [COEFF_W-1:0]  coef [3];
	logic signed [PROD_W-1:0]   pc_s2 [3];
	logic signed [PROD_W-1:0]   pe_s2 [3];
	logic [PROD_W-1:0]          mag [3];
	logic signed [ACC_W-1:0]    c_s3;
	logic [ACC_W-1:0]           e_s3;
	logic signed [CTR_W-1:0]    centre_s4;
	logic [EXT_W-1:0]           ext_s4;
	logic signed [CORNER_W-1:0] ext_se;
	logic signed [CORNER_W-1:0] lo_raw;
	logic signed [CORNER_W-1:0] hi_raw;
	logic                       lo_fits;
	logic                       hi_fits;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			coef[j] = row[j*COEFF_W +: COEFF_W];
			mag[j]  = pe_s2[j][PROD_W-1] ? (~pe_s2[j] + PROD_W'(1)) : pe_s2[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int j = 0; j < 3; j++) begin
				pc_s2[j] <= coef[j] * sum_s1[j];
				pe_s2[j] <= coef[j] * dif_s1[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			c_s3 <= ACC_W'(pc_s2[0]) + ACC_W'(pc_s2[1]) + ACC_W'(pc_s2[2]);
			e_s3 <= ACC_W'(mag[0]) + ACC_W'(mag[1]) + ACC_W'(mag[2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			centre_s4 <= CTR_W'(c_s3 >>> RSHIFT) + CTR_W'(shift);
			ext_s4    <= e_s3[ACC_W-1:RSHIFT];
		end
	end

	// corners fit when every bit above the output sign bit matches it
	always_comb begin
		ext_se  = $signed(CORNER_W'(ext_s4));
		lo_raw  = CORNER_W'(centre_s4) - ext_se;
		hi_raw  = CORNER_W'(centre_s4) + ext_se;
		lo_fits = (&lo_raw[CORNER_W-1:COORD_W-1]) || !(|lo_raw[CORNER_W-1:COORD_W-1]);
		hi_fits = (&hi_raw[CORNER_W-1:COORD_W-1]) || !(|hi_raw[CORNER_W-1:COORD_W-1]);
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			lower_s5 <= lo_fits ? lo_raw[COORD_W-1:0]
				: (lo_raw[CORNER_W-1] ? SAT_MIN[COORD_W-1:0] : SAT_MAX[COORD_W-1:0]);
			upper_s5 <= hi_fits ? hi_raw[COORD_W-1:0]
				: (hi_raw[CORNER_W-1] ? SAT_MIN[COORD_W-1:0] : SAT_MAX[COORD_W-1:0]);
			clip_s5  <= !lo_fits || !hi_fits;
		end
	end

endmodule

FILE: hw/rtl/aabb3d_affine_transform.sv
`timescale 1ns / 1ps
// One box per cycle while out_stall is low; five register stages (sum/difference,
// products, accumulate, shift and translate, corners with saturation), each with
// its own valid, lie between the accepting edge and the output register.
// A stalled stage only holds back the stages behind it; bubbles are squeezed out.
// Reset (arst_n low, asynchronous): all valids clear, the transform returns to identity.
module aabb3d_affine_transform (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_write,
	input  logic [aabbt_pkg::REG_IDX_W-1:0]          cfg_index,
	input  logic [aabbt_pkg::CFG_W-1:0]              cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [aabbt_pkg::COORD_W-1:0]     lower_x,
	input  logic signed [aabbt_pkg::COORD_W-1:0]     lower_y,
	input  logic signed [aabbt_pkg::COORD_W-1:0]     lower_z,
	input  logic signed [aabbt_pkg::COORD_W-1:0]     upper_x,
	input  logic signed [aabbt_pkg::COORD_W-1:0]     upper_y,
	input  logic signed [aabbt_pkg::COORD_W-1:0]     upper_z,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [aabbt_pkg::COORD_W-1:0]     out_lower_x,
	output logic signed [aabbt_pkg::COORD_W-1:0]     out_lower_y,
	output logic signed [aabbt_pkg::COORD_W-1:0]     out_lower_z,
	output logic signed [aabbt_pkg::COORD_W-1:0]     out_upper_x,
	output logic signed [aabbt_pkg::COORD_W-1:0]     out_upper_y,
	output logic signed [aabbt_pkg::COORD_W-1:0]     out_upper_z,
	output logic                                     clipped
);
	import aabbt_pkg::*;

	logic [ROW_W-1:0]          row_q [3];
	logic signed [COORD_W-1:0] shift_q [3];
	sum_t                      sum_s1 [3];
	sum_t                      dif_s1 [3];
	logic                      v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic                      en1;
	stage_en_t                 en;
	logic [2:0]                clip_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]   <= ROW_X_RST;
			row_q[1]   <= ROW_Y_RST;
			row_q[2]   <= ROW_Z_RST;
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROW_X:   row_q[0]   <= cfg_data[ROW_W-1:0];
				REG_ROW_Y:   row_q[1]   <= cfg_data[ROW_W-1:0];
				REG_ROW_Z:   row_q[2]   <= cfg_data[ROW_W-1:0];
				REG_SHIFT_X: shift_q[0] <= cfg_data[COORD_W-1:0];
				REG_SHIFT_Y: shift_q[1] <= cfg_data[COORD_W-1:0];
				REG_SHIFT_Z: shift_q[2] <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// a stage advances when it is empty or the stage after it advances
	always_comb begin
		en.s5    = !v5_s5 || !out_stall;
		en.s4    = !v4_s4 || en.s5;
		en.s3    = !v3_s3 || en.s4;
		en.s2    = !v2_s2 || en.s3;
		en1      = !v1_s1 || en.s2;
		in_stall = !en1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (en1)    v1_s1 <= in_valid;
			if (en.s2)  v2_s2 <= v1_s1;
			if (en.s3)  v3_s3 <= v2_s2;
			if (en.s4)  v4_s4 <= v3_s3;
			if (en.s5)  v5_s5 <= v4_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sum_s1[0] <= SUM_W'(lower_x) + SUM_W'(upper_x);
			sum_s1[1] <= SUM_W'(lower_y) + SUM_W'(upper_y);
			sum_s1[2] <= SUM_W'(lower_z) + SUM_W'(upper_z);
			dif_s1[0] <= SUM_W'(upper_x) - SUM_W'(lower_x);
			dif_s1[1] <= SUM_W'(upper_y) - SUM_W'(lower_y);
			dif_s1[2] <= SUM_W'(upper_z) - SUM_W'(lower_z);
		end
	end

	aabbt_axis u_axis_x (
		.clk      (clk),
		.en       (en),
		.row      (row_q[0]),
		.shift    (shift_q[0]),
		.sum_s1   (sum_s1),
		.dif_s1   (dif_s1),
		.lower_s5 (out_lower_x),
		.upper_s5 (out_upper_x),
		.clip_s5  (clip_s5[0])
	);

	aabbt_axis u_axis_y (
		.clk      (clk),
		.en       (en),
		.row      (row_q[1]),
		.shift    (shift_q[1]),
		.sum_s1   (sum_s1),
		.dif_s1   (dif_s1),
		.lower_s5 (out_lower_y),
		.upper_s5 (out_upper_y),
		.clip_s5  (clip_s5[1])
	);

	aabbt_axis u_axis_z (
		.clk      (clk),
		.en       (en),
		.row      (row_q[2]),
		.shift    (shift_q[2]),
		.sum_s1   (sum_s1),
		.dif_s1   (dif_s1),
		.lower_s5 (out_lower_z),
		.upper_s5 (out_upper_z),
		.clip_s5  (clip_s5[2])
	);

	assign out_valid = v5_s5;
	assign clipped   = |clip_s5;

endmodule

FILE: hw/rtl/aabbt_checker.sv
`timescale 1ns / 1ps

module aabbt_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_stall,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [aabbt_pkg::COORD_W-1:0]  out_lower_x,
	input  logic signed [aabbt_pkg::COORD_W-1:0]  out_lower_y,
	input  logic signed [aabbt_pkg::COORD_W-1:0]  out_lower_z,
	input  logic signed [aabbt_pkg::COORD_W-1:0]  out_upper_x,
	input  logic signed [aabbt_pkg::COORD_W-1:0]  out_upper_y,
	input  logic signed [aabbt_pkg::COORD_W-1:0]  out_upper_z,
	input  logic                                  clipped
);
	import aabbt_pkg::*;

	// hold a stalled transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out transaction dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_lower_x) && $stable(out_upper_x)
			&& $stable(out_lower_y) && $stable(out_upper_y)
			&& $stable(out_lower_z) && $stable(out_upper_z) && $stable(clipped))
		else $error("stalled out payload changed");

	// an empty output register means the whole pipe can advance
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// extent is never negative and saturation is monotonic
	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_lower_x <= out_upper_x) && (out_lower_y <= out_upper_y)
			&& (out_lower_z <= out_upper_z))
		else $error("output box corners out of order");

endmodule

bind aabb3d_affine_transform aabbt_checker u_aabbt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_lower_x (out_lower_x),
	.out_lower_y (out_lower_y),
	.out_lower_z (out_lower_z),
	.out_upper_x (out_upper_x),
	.out_upper_y (out_upper_y),
	.out_upper_z (out_upper_z),
	.clipped     (clipped)
);
